// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers: implication on the rising clock edge, reset gated.
`define AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/kst_pkg.sv
`timescale 1ns / 1ps
package kst_pkg;
  localparam int BUCKETS = 64;
  localparam int ENTRIES = 64;
  localparam int KEY_STRIDE_LOG2 = 3;
  localparam int BW = $clog2(BUCKETS);
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_INSERT  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMIT    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef logic [BW-1:0] bidx_t;
  typedef logic [EW-1:0] eidx_t;
  typedef logic [CW-1:0] cnt_t;

  typedef struct packed {
    logic       load;       // latch input item, read bucket head
    logic       walk_rd;    // read entry at cur
    logic       step;       // cur <= next
    logic       upd_sum;    // write saturated sum into cur
    logic       insert;     // append new entry
    logic       bscan_rd;   // extract: read head of scan bucket
    logic       bscan_inc;  // advance scan bucket, clear its head
    logic       clear;      // reset count after extract
    logic       set_cur_head;
    logic [2:0] res_status;
    logic       res_last;
    logic       res_load;   // capture result
  } kst_cmd_t;

  typedef struct packed {
    logic mode;
    logic head_ok;
    logic key_hit;
    logic next_ok;
    logic full;
    logic empty;
    logic scan_done;
  } kst_sts_t;

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                 input logic signed [31:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + 49'(b);
    if (s[48] != s[47]) sat_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else sat_add = s[47:0];
  endfunction
endpackage

// File: hdl/kst_if.sv
`timescale 1ns / 1ps
interface kst_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] key;
  logic signed [31:0] delta;
  modport source (output valid, mode, key, delta, input ready);
  modport sink (input valid, mode, key, delta, output ready);
endinterface

interface kst_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] out_key;
  logic signed [47:0] out_sum;
  logic [6:0]  pair_count;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, out_key, out_sum, pair_count, status, last, input ready);
  modport sink (input valid, out_key, out_sum, pair_count, status, last, output ready);
endinterface

// File: hdl/keyed_sum_hash_table_core.sv
`timescale 1ns / 1ps
// Apply: the bucket head is read, then chain entries are read and compared in turn; a hit
// updates the sum, a miss inserts or reports full; a new transaction waits until the result is taken.
// Extract: buckets are scanned in order and each pair is read and emitted, stalling while the
// output is full; one pair leaves at a time because the walk shares the entry memory read port.
// The last-pair flag of an extract is held in a one-pair lookahead register.
// Reset: synchronous active-low; clears bucket valid bits, link flags and pair count.
`include "assert_macros.svh"
module keyed_sum_hash_table_core (
  input logic clk,
  input logic rst_n,
  kst_in_if.sink    in_ch,
  kst_out_if.source out_ch
);
  kst_pkg::kst_cmd_t cmd;
  kst_pkg::kst_sts_t sts;
  logic        c_out_valid, c_out_ready;
  logic [31:0] r_key;
  logic signed [47:0] r_sum;
  logic [6:0]  r_cnt;
  logic [2:0]  r_st;
  logic        r_last;

  // Lookahead: an emitted pair is held until the next one or end of scan, so
  // the final pair can carry last.
  logic        h_v_r;
  logic [31:0] h_key_r;
  logic signed [47:0] h_sum_r;
  logic [6:0]  h_cnt_r;
  logic [2:0]  h_st_r;
  logic        h_last_r;
  logic        flush;

  kst_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(c_out_valid), .out_ready(c_out_ready),
    .cmd, .sts
  );

  kst_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_mode(in_ch.mode), .in_key(in_ch.key), .in_delta(in_ch.delta),
    .res_key(r_key), .res_sum(r_sum), .res_count(r_cnt),
    .res_status(r_st), .res_last(r_last)
  );

  assign flush = cmd.clear;
  // controller result is taken when the holding slot is free or drains
  assign c_out_ready = !h_v_r || out_ch.ready;
  assign out_ch.valid = h_v_r && (h_last_r || c_out_valid);
  assign out_ch.out_key = h_key_r;
  assign out_ch.out_sum = h_sum_r;
  assign out_ch.pair_count = h_cnt_r;
  assign out_ch.status = h_st_r;
  assign out_ch.last = h_last_r;

  logic fwd;
  assign fwd = h_v_r && !h_last_r && c_out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      h_last_r <= 1'b0;
    end else begin
      if (flush && h_v_r) h_last_r <= 1'b1;
      if ((c_out_valid && c_out_ready) || fwd) begin
        h_v_r <= 1'b1;
        h_last_r <= r_last;
      end else if (out_ch.valid && out_ch.ready) begin
        h_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((c_out_valid && c_out_ready) || fwd) begin
      h_key_r <= r_key;
      h_sum_r <= r_sum;
      h_cnt_r <= r_cnt;
      h_st_r  <= r_st;
    end
  end

  `AST_IMPL(a_last_on_apply, out_ch.valid && (out_ch.status != kst_pkg::ST_EMIT), out_ch.last)
  `AST_IMPL(a_no_accept_busy, in_ch.valid && in_ch.ready, !h_v_r || h_last_r)
  `AST_NEXT(a_clear_zero, cmd.clear, sts.empty)
endmodule

// File: hdl/kst_datapath.sv
`timescale 1ns / 1ps
module kst_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  kst_pkg::kst_cmd_t  cmd,
  output kst_pkg::kst_sts_t  sts,
  input  logic               in_mode,
  input  logic [31:0]        in_key,
  input  logic signed [31:0] in_delta,
  output logic [31:0]        res_key,
  output logic signed [47:0] res_sum,
  output logic [6:0]         res_count,
  output logic [2:0]         res_status,
  output logic               res_last
);
  // Entry memories; the head store keeps valid bits in flops.
  logic [31:0]        ekey_mem [kst_pkg::ENTRIES];
  logic signed [47:0] esum_mem [kst_pkg::ENTRIES];
  kst_pkg::eidx_t     enext_mem [kst_pkg::ENTRIES];
  logic [kst_pkg::ENTRIES-1:0] nok_r;
  kst_pkg::eidx_t     head_mem [kst_pkg::BUCKETS];
  kst_pkg::eidx_t     tail_mem [kst_pkg::BUCKETS];
  logic [kst_pkg::BUCKETS-1:0] hok_r;

  logic               mode_r;
  logic [31:0]        key_r;
  logic signed [31:0] delta_r;
  kst_pkg::bidx_t     bkt_r, scan_r;
  kst_pkg::eidx_t     cur_r, head_rd_r, next_rd_r, tail_rd_r;
  logic [31:0]        ekey_rd_r;
  logic signed [47:0] esum_rd_r;
  kst_pkg::cnt_t      cnt_r, cnt_snap_r;
  logic               scan_end_r;

  kst_pkg::bidx_t bsel;
  kst_pkg::eidx_t nidx;
  logic signed [47:0] newsum;

  // head read on the accepting edge uses the incoming key's bucket
  assign bsel   = cmd.bscan_rd ? scan_r :
                  (cmd.load ? in_key[kst_pkg::KEY_STRIDE_LOG2 +: kst_pkg::BW] : bkt_r);
  assign nidx   = kst_pkg::eidx_t'(cnt_r);
  assign newsum = kst_pkg::sat_add(esum_rd_r, delta_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      delta_r <= in_delta;
      bkt_r   <= in_key[kst_pkg::KEY_STRIDE_LOG2 +: kst_pkg::BW];
      cnt_snap_r <= cnt_r;
    end
    head_rd_r <= head_mem[bsel];
    tail_rd_r <= tail_mem[bkt_r];
    if (cmd.set_cur_head) cur_r <= head_rd_r;
    if (cmd.step) cur_r <= next_rd_r;
    if (cmd.walk_rd) begin
      ekey_rd_r <= ekey_mem[cur_r];
      esum_rd_r <= esum_mem[cur_r];
      next_rd_r <= enext_mem[cur_r];
    end
    if (cmd.upd_sum) esum_mem[cur_r] <= newsum;
    if (cmd.insert) begin
      ekey_mem[nidx] <= key_r;
      esum_mem[nidx] <= 48'(delta_r);
      tail_mem[bkt_r] <= nidx;
      if (!hok_r[bkt_r]) head_mem[bkt_r] <= nidx;
      else enext_mem[tail_rd_r] <= nidx;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_last   <= cmd.res_last;
      unique case (cmd.res_status)
        kst_pkg::ST_ADDED: begin
          res_key <= key_r; res_sum <= newsum; res_count <= 7'(cnt_r);
        end
        kst_pkg::ST_INSERT: begin
          res_key <= key_r; res_sum <= 48'(delta_r); res_count <= 7'(cnt_r + 1'b1);
        end
        kst_pkg::ST_FULL: begin
          res_key <= key_r; res_sum <= '0; res_count <= 7'(cnt_r);
        end
        kst_pkg::ST_EMIT: begin
          res_key <= ekey_rd_r; res_sum <= esum_rd_r; res_count <= 7'(cnt_snap_r);
        end
        default: begin
          res_key <= '0; res_sum <= '0; res_count <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hok_r <= '0;
      nok_r <= '0;
      cnt_r <= '0;
      scan_r <= '0;
      scan_end_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_r <= '0;
        scan_end_r <= 1'b0;
      end
      if (cmd.insert) begin
        cnt_r <= cnt_r + 1'b1;
        nok_r[nidx] <= 1'b0;
        if (!hok_r[bkt_r]) hok_r[bkt_r] <= 1'b1;
        else nok_r[tail_rd_r] <= 1'b1;
      end
      if (cmd.bscan_inc) begin
        hok_r[scan_r] <= 1'b0;
        scan_r <= scan_r + 1'b1;
        scan_end_r <= (scan_r == kst_pkg::bidx_t'(kst_pkg::BUCKETS - 1));
      end
      if (cmd.clear) begin
        cnt_r <= '0;
        nok_r <= '0;
      end
    end
  end

  assign sts.mode      = mode_r;
  assign sts.head_ok   = hok_r[cmd.bscan_rd ? scan_r : bkt_r];
  assign sts.key_hit   = (ekey_rd_r == key_r);
  assign sts.next_ok   = nok_r[cur_r];
  assign sts.full      = (cnt_r >= kst_pkg::cnt_t'(kst_pkg::ENTRIES));
  assign sts.empty     = (cnt_r == '0);
  assign sts.scan_done = scan_end_r;
endmodule

// File: hdl/kst_ctrl.sv
`timescale 1ns / 1ps
module kst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output kst_pkg::kst_cmd_t cmd,
  input  kst_pkg::kst_sts_t sts
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HEAD  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_CMP   = 10'b0000001000,
    S_RES   = 10'b0000010000,
    S_SBKT  = 10'b0000100000,
    S_SHEAD = 10'b0001000000,
    S_SRD   = 10'b0010000000,
    S_SEMIT = 10'b0100000000,
    S_SOUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        // head word read on the accepting edge at the incoming bucket
        if (sts.mode) begin
          if (sts.empty) begin
            cmd.res_load = 1'b1; cmd.res_status = kst_pkg::ST_EMPTY; cmd.res_last = 1'b1;
            ov_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SBKT;
          end
        end else if (sts.head_ok) begin
          cmd.set_cur_head = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.key_hit) begin
          cmd.upd_sum = 1'b1;
          cmd.res_load = 1'b1; cmd.res_status = kst_pkg::ST_ADDED; cmd.res_last = 1'b1;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (sts.next_ok) begin
          cmd.step = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        cmd.res_load = 1'b1; cmd.res_last = 1'b1;
        if (sts.full) begin
          cmd.res_status = kst_pkg::ST_FULL;
        end else begin
          cmd.res_status = kst_pkg::ST_INSERT;
          cmd.insert = 1'b1;
        end
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_SBKT: begin
        if (sts.scan_done) begin
          // final pair has to reach the holding slot before it is tagged last
          if (!ov_r) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.bscan_rd = 1'b1;
          state_nxt = S_SHEAD;
        end
      end
      S_SHEAD: begin
        cmd.bscan_rd = 1'b1;
        if (sts.head_ok) begin
          cmd.set_cur_head = 1'b1;
          state_nxt = S_SRD;
        end
        cmd.bscan_inc = !sts.head_ok;
        if (!sts.head_ok) state_nxt = S_SBKT;
      end
      S_SRD: begin
        cmd.walk_rd = 1'b1;
        state_nxt = S_SEMIT;
      end
      S_SEMIT: begin
        // wait for the output register to drain before loading a pair
        if (!ov_r || out_ready) begin
          cmd.res_load = 1'b1; cmd.res_status = kst_pkg::ST_EMIT;
          cmd.res_last = 1'b0;
          ov_nxt = 1'b1;
          state_nxt = S_SOUT;
        end
      end
      S_SOUT: begin
        if (sts.next_ok) begin
          cmd.step = 1'b1;
          state_nxt = S_SRD;
        end else begin
          cmd.bscan_inc = 1'b1;
          state_nxt = S_SBKT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
